// ===== design/assert_macros.svh =====
// Assertion helpers, included by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== design/rrfp_pkg.sv =====
`default_nettype none

package rrfp_pkg;

   localparam int PAYLOAD_BYTES_DEF = 15;
   localparam int MARK_BYTES        = 4;

   localparam logic [7:0] HEAD_MARK [MARK_BYTES] = '{8'hFD, 8'hFC, 8'hFB, 8'hFA};
   localparam logic [7:0] TAIL_MARK [MARK_BYTES] = '{8'h04, 8'h03, 8'h02, 8'h01};

   typedef struct packed {
      logic [7:0]  target_state;
      logic [7:0]  motion_distance;
      logic [7:0]  motion_energy;
      logic [7:0]  still_distance;
      logic [7:0]  still_energy;
      logic [15:0] detect_distance;
   } report_type;

   // Outcome of the incoming byte against the window as it will stand after it.
   typedef struct packed {
      logic       hit;
      report_type report;
   } frame_hit_type;

endpackage

`default_nettype wire

// ===== design/rrfp_channels.sv =====
`default_nettype none

interface rrfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  target_state;
   logic [7:0]  motion_distance;
   logic [7:0]  motion_energy;
   logic [7:0]  still_distance;
   logic [7:0]  still_energy;
   logic [15:0] detect_distance;

   modport source (output valid, output target_state, output motion_distance,
                   output motion_energy, output still_distance, output still_energy,
                   output detect_distance, input ready);
   modport sink   (input valid, input target_state, input motion_distance,
                   input motion_energy, input still_distance, input still_energy,
                   input detect_distance, output ready);
endinterface

`default_nettype wire

// ===== design/rrfp_window.sv =====
`default_nettype none

module rrfp_window #(
   parameter int PAYLOAD_BYTES = rrfp_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire logic [7:0]             rx_byte,
   output rrfp_pkg::frame_hit_type     frame_hit
);
   import rrfp_pkg::*;

   localparam int FRAME_BYTES = PAYLOAD_BYTES + 2 * MARK_BYTES;
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

   // Shift line: the newest byte sits in the last tap. The fill count says
   // how many of the newest taps belong to the current window.
   logic [7:0]       window_ff [FRAME_BYTES];
   logic [7:0]       window_in [FRAME_BYTES];
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             full_in;
   logic             marks_ok;

   always_comb begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[FRAME_BYTES - 1] = rx_byte;

      full_in  = (fill_ff >= CNT_W'(FRAME_BYTES - 1));
      marks_ok = 1'b1;
      for (int k = 0; k < MARK_BYTES; k++) begin
         if (window_in[k] != HEAD_MARK[k] ||
             window_in[FRAME_BYTES - MARK_BYTES + k] != TAIL_MARK[k]) begin
            marks_ok = 1'b0;
         end
      end
   end

   always_comb begin
      frame_hit.hit                    = full_in && marks_ok;
      frame_hit.report.target_state    = window_in[MARK_BYTES];
      frame_hit.report.motion_distance = window_in[MARK_BYTES + 1];
      frame_hit.report.motion_energy   = window_in[MARK_BYTES + 3];
      frame_hit.report.still_distance  = window_in[MARK_BYTES + 5];
      frame_hit.report.still_energy    = window_in[MARK_BYTES + 7];
      frame_hit.report.detect_distance = {window_in[MARK_BYTES + 2],
                                          window_in[MARK_BYTES + 1]};
   end

   always_comb begin
      priority if (frame_hit.hit) begin
         fill_in = '0;
      end else if (fill_ff < CNT_W'(FRAME_BYTES)) begin
         fill_in = fill_ff + CNT_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (take) begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rrfp_report_reg.sv =====
`default_nettype none

module rrfp_report_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire rrfp_pkg::frame_hit_type frame_hit,
   input  wire logic                out_ready,
   output logic                     out_valid,
   output rrfp_pkg::report_type     out_report
);
   import rrfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   report_type report_ff;
   logic       load;

   assign load = take && frame_hit.hit;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         report_ff <= frame_hit.report;
      end
   end

   assign out_valid  = valid_ff;
   assign out_report = report_ff;

endmodule

`default_nettype wire

// ===== design/radar_report_frame_parser_unit.sv =====
// Radar report frame parser.
// req_chan carries one received serial byte per item (rx_byte). rsp_chan
// carries one decoded report per complete frame: FD FC FB FA, then
// PAYLOAD_BYTES payload bytes, then 04 03 02 01.
// One byte per cycle unless a frame-completing byte waits on a stalled report,
// set by the window shift line and parallel compare of its eight marker taps.
// Latency: the report appears on rsp_chan in the cycle after the last tail
// byte is accepted and is held until the receiver takes it.
// Bytes ahead of a frame simply fall out of the oldest end of the window;
// a matched frame empties the window, so none of its bytes are reused.
// While a report waits, bytes keep being accepted; only a byte that would
// complete another frame is held back until the waiting report is taken.
// Reset (synchronous, active high) empties the window and drops any report
// that has not yet been taken; no clearing pass is needed afterwards.
`default_nettype none
`include "assert_macros.svh"

module radar_report_frame_parser_unit #(
   parameter int PAYLOAD_BYTES = rrfp_pkg::PAYLOAD_BYTES_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   rrfp_req_if.sink       req_chan,
   rrfp_rsp_if.source     rsp_chan
);
   import rrfp_pkg::*;

   frame_hit_type frame_hit;
   report_type    report;
   logic          take;

   // The output register can always take a report once the waiting one is
   // leaving, so only a frame-completing byte against a stalled report waits.
   assign req_chan.ready = !rsp_chan.valid || rsp_chan.ready || !frame_hit.hit;
   assign take           = req_chan.valid && req_chan.ready;

   rrfp_window #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_chan.rx_byte),
      .frame_hit (frame_hit)
   );

   rrfp_report_reg u_report (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .frame_hit  (frame_hit),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_report (report)
   );

   assign rsp_chan.target_state    = report.target_state;
   assign rsp_chan.motion_distance = report.motion_distance;
   assign rsp_chan.motion_energy   = report.motion_energy;
   assign rsp_chan.still_distance  = report.still_distance;
   assign rsp_chan.still_energy    = report.still_energy;
   assign rsp_chan.detect_distance = report.detect_distance;

   // A stalled report must never be overwritten by a new frame.
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_chan.valid && !rsp_chan.ready && frame_hit.hit, !req_chan.ready)
   // An accepted frame-completing byte always yields a report next cycle.
   `ASSERT_NEXT(a_hit_reported, clock, reset, take && frame_hit.hit, rsp_chan.valid)
   // A match empties the window, so the very next byte cannot match again.
   `ASSERT_NEXT(a_window_emptied, clock, reset, take && frame_hit.hit, !frame_hit.hit)

endmodule

`default_nettype wire
